>>> rtl/sahud_pkg.sv
// shared types and constants for the stereo hold upsampler with dither
`default_nettype none
package sahud_pkg;

    localparam int ACC_W      = 29;
    localparam int SAMPLE_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int OUT_RATE_W = 28;
    localparam int AUD_RATE_W = 18;
    localparam int ERR_W      = 10;
    localparam int LO_W       = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OUT_RATE_W;

    localparam logic [CFG_IDX_W-1:0]  CFG_OUT_RATE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_AUDIO_RATE = 1'd1;

    localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST   = 28'd20000000;
    localparam logic [AUD_RATE_W-1:0] AUD_RATE_RST   = 18'd32000;

    localparam logic [SAMPLE_W-1:0]   SIGN_FLIP      = 16'h8000;
    localparam logic [ERR_W:0]        LO_FULL        = 11'h1FF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] left_byte;
        logic [BYTE_W-1:0] right_byte;
        logic              took_sample;
    } t_out_req;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage
`default_nettype wire

>>> rtl/stereo_audio_hold_upsample_dither.sv
// top level: phase accumulator, two channel lanes and the merged output register
// an accepted request's result lands in the output register in the cycle after
// one request per cycle unless the output stalls; accumulator add, compare and subtract
// are combinational; the input stays ready while the output drains in the same cycle
// synchronous active-low reset clears rates to defaults, accumulator, holds and errors
`default_nettype none
module stereo_audio_hold_upsample_dither import sahud_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_req               i_in_req,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_req                   o_out_req
);

    t_cfg_wr           cfg;
    logic              accept;
    logic              took;
    logic [BYTE_W-1:0] left_byte;
    logic [BYTE_W-1:0] right_byte;
    logic              r_valid;
    t_out_req          r_out;

    always_comb begin
        cfg.we   = i_cfg_we;
        cfg.idx  = i_cfg_idx;
        cfg.data = i_cfg_data;
    end

    assign o_in_ready = !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    sahud_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_en    (accept),
        .o_took  (took)
    );

    sahud_lane u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_took   (took),
        .i_sample (i_in_req.left_sample),
        .o_byte   (left_byte)
    );

    sahud_lane u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_took   (took),
        .i_sample (i_in_req.right_sample),
        .o_byte   (right_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.left_byte   <= left_byte;
            r_out.right_byte  <= right_byte;
            r_out.took_sample <= took;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_req   = r_out;

endmodule
`default_nettype wire

>>> rtl/sahud_phase.sv
// phase accumulator with rate registers, decides when a sample pair is taken
`default_nettype none
module sahud_phase import sahud_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_en,
    output logic         o_took
);

    localparam int CMP_W = (ACC_W > OUT_RATE_W) ? ACC_W : OUT_RATE_W;

    logic [OUT_RATE_W-1:0] r_out_rate;
    logic [AUD_RATE_W-1:0] r_audio_rate;
    logic [ACC_W-1:0]      r_acc;
    logic [ACC_W-1:0]      n_acc;
    logic [ACC_W:0]        sum;
    logic [CMP_W-1:0]      sat;
    logic [CMP_W-1:0]      rate_ext;
    logic [CMP_W-1:0]      diff;

    always_comb begin
        sum      = {1'b0, r_acc} + (ACC_W+1)'(r_audio_rate);
        sat      = sum[ACC_W] ? CMP_W'({ACC_W{1'b1}}) : CMP_W'(sum[ACC_W-1:0]);
        rate_ext = CMP_W'(r_out_rate);
        o_took   = (sat >= rate_ext);
        diff     = sat - rate_ext;
        n_acc    = o_took ? diff[ACC_W-1:0] : sat[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_rate   <= OUT_RATE_RST;
            r_audio_rate <= AUD_RATE_RST;
            r_acc        <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_OUT_RATE:   r_out_rate   <= i_cfg.data[OUT_RATE_W-1:0];
                    CFG_AUDIO_RATE: r_audio_rate <= i_cfg.data[AUD_RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_en) begin
                r_acc <= n_acc;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/sahud_lane.sv
// one channel: sample hold, offset binary, error feedback to an 8-bit code
`default_nettype none
module sahud_lane import sahud_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_took,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic [BYTE_W-1:0]        o_byte
);

    logic [SAMPLE_W-1:0] r_held;
    logic [SAMPLE_W-1:0] n_held;
    logic [ERR_W-1:0]    r_err;
    logic [ERR_W-1:0]    n_err;
    logic [ERR_W:0]      e_sum;
    logic                carry;

    always_comb begin
        n_held = i_took ? (i_sample ^ SIGN_FLIP) : r_held;
        e_sum  = (ERR_W+1)'(r_err) + (ERR_W+1)'(n_held[LO_W-1:0]);
        carry  = (e_sum >= LO_FULL);
        n_err  = carry ? ERR_W'(e_sum - LO_FULL) : e_sum[ERR_W-1:0];
        o_byte = {n_held[SAMPLE_W-1:LO_W], 1'b0} + BYTE_W'(carry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_err  <= '0;
        end else if (i_en) begin
            r_held <= n_held;
            r_err  <= n_err;
        end
    end

endmodule
`default_nettype wire
